@@ design/rult_pkg.sv @@
// rult_pkg: shared types, codes and sizes for the unstable log term store
`timescale 1ns / 1ps

package rult_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned XW    = 64;

  localparam logic [2:0] CMD_APPEND      = 3'd0;
  localparam logic [2:0] CMD_TERM_QUERY  = 3'd1;
  localparam logic [2:0] CMD_STABLE_ENT  = 3'd2;
  localparam logic [2:0] CMD_RESTORE     = 3'd3;
  localparam logic [2:0] CMD_STABLE_SNAP = 3'd4;

  typedef enum logic [2:0] {
    ERR_OK            = 3'd0,
    ERR_SNAP_PENDING  = 3'd1,
    ERR_EMPTY         = 3'd2,
    ERR_LAST_MISMATCH = 3'd3,
    ERR_NO_SNAP       = 3'd4,
    ERR_SNAP_MISMATCH = 3'd5,
    ERR_BOUNDS        = 3'd6,
    ERR_FULL          = 3'd7
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic apply;
    logic reply;
  } ctl_t;

  typedef struct packed {
    logic [2:0]    command;
    logic [XW-1:0] index;
    logic [XW-1:0] term;
    logic          first_of_batch;
  } in_word_t;

  typedef struct packed {
    logic          term_found;
    logic [XW-1:0] term_value;
    logic          first_valid;
    logic [XW-1:0] first_index;
    logic          last_valid;
    logic [XW-1:0] last_index;
    logic [2:0]    error_code;
  } out_word_t;

endpackage

@@ design/rult_ram.sv @@
// rult_ram: generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module rult_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rult_ctrl.sv @@
// rult_ctrl: command sequencer for the unstable log term store
`timescale 1ns / 1ps

module rult_ctrl import rult_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_REPLY;
      ST_REPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      ST_EVAL:  ctl.eval  = 1'b1;
      ST_APPLY: ctl.apply = 1'b1;
      ST_REPLY: ctl.reply = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

@@ design/rult_dp.sv @@
// rult_dp: log state registers, index arithmetic and term memory
`timescale 1ns / 1ps

module rult_dp import rult_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_t      ctl,
  input  in_word_t  in_word,
  output out_word_t out_word
);

  // latched command word
  logic [2:0]    cmd_r;
  logic [XW-1:0] idx_r, term_r;
  logic          first_r;

  // log state
  logic [XW-1:0] offset_r, offset_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          snap_valid_r, snap_valid_nxt;
  logic [XW-1:0] snap_idx_r, snap_idx_nxt;
  logic [XW-1:0] snap_term_r, snap_term_nxt;

  // decisions taken in the evaluate cycle
  err_t          app_err_r, app_err_nxt;
  logic          app_trunc_r, app_trunc_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic          hit_entry_r, hit_entry_nxt;
  logic          hit_snap_r, hit_snap_nxt;
  logic [XW-1:0] end_r;

  // result of the apply cycle
  logic          found_r, found_nxt;
  logic [XW-1:0] value_r, value_nxt;
  err_t          err_r, err_nxt;

  logic [XW-1:0] idx_delta;
  logic          idx_ge, idx_le, d_eq_cnt, d_lt_cnt;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] raddr;
  logic [XW-1:0] rdata;
  logic          we;

  assign idx_delta = idx_r - offset_r;
  assign idx_ge    = idx_r >= offset_r;
  assign idx_le    = idx_r <= offset_r;
  assign d_eq_cnt  = idx_delta == XW'(count_r);
  assign d_lt_cnt  = idx_delta < XW'(count_r);
  assign count_m1  = count_r - CW'(1);
  assign raddr     = (cmd_r == CMD_STABLE_ENT) ? count_m1[AW-1:0] : idx_delta[AW-1:0];

  // append placement and lookup hits
  always_comb begin
    app_err_nxt   = ERR_OK;
    app_trunc_nxt = 1'b0;
    keep_nxt      = count_r;
    priority if (idx_ge && d_eq_cnt) begin
      keep_nxt = count_r;
    end else if (!first_r) begin
      app_err_nxt = ERR_BOUNDS;
    end else if (idx_le) begin
      app_trunc_nxt = 1'b1;
      keep_nxt      = '0;
    end else if (d_lt_cnt) begin
      keep_nxt = idx_delta[CW-1:0];
    end else begin
      app_err_nxt = ERR_BOUNDS;
    end
    if (app_err_nxt == ERR_OK && keep_nxt >= CW'(DEPTH)) begin
      app_err_nxt = ERR_FULL;
    end
    hit_entry_nxt = idx_ge && d_lt_cnt;
    hit_snap_nxt  = !idx_ge && snap_valid_r && (idx_r == snap_idx_r);
  end

  // state update from the registered decisions and the memory read
  always_comb begin
    offset_nxt     = offset_r;
    count_nxt      = count_r;
    snap_valid_nxt = snap_valid_r;
    snap_idx_nxt   = snap_idx_r;
    snap_term_nxt  = snap_term_r;
    found_nxt      = 1'b0;
    value_nxt      = '0;
    err_nxt        = ERR_OK;
    we             = 1'b0;
    unique case (cmd_r)
      CMD_APPEND: begin
        err_nxt = app_err_r;
        if (app_err_r == ERR_OK) begin
          if (app_trunc_r) offset_nxt = idx_r;
          count_nxt = keep_r + CW'(1);
          we        = 1'b1;
        end
      end
      CMD_TERM_QUERY: begin
        found_nxt = hit_entry_r || hit_snap_r;
        if (hit_entry_r) begin
          value_nxt = rdata;
        end else if (hit_snap_r) begin
          value_nxt = snap_term_r;
        end
      end
      CMD_STABLE_ENT: begin
        priority if (snap_valid_r) begin
          err_nxt = ERR_SNAP_PENDING;
        end else if (count_r == '0) begin
          err_nxt = ERR_EMPTY;
        end else if ((end_r - XW'(1)) != idx_r || rdata != term_r) begin
          err_nxt = ERR_LAST_MISMATCH;
        end else begin
          offset_nxt = end_r;
          count_nxt  = '0;
        end
      end
      CMD_RESTORE: begin
        count_nxt      = '0;
        offset_nxt     = idx_r + XW'(1);
        snap_valid_nxt = 1'b1;
        snap_idx_nxt   = idx_r;
        snap_term_nxt  = term_r;
      end
      CMD_STABLE_SNAP: begin
        priority if (!snap_valid_r) begin
          err_nxt = ERR_NO_SNAP;
        end else if (snap_idx_r != idx_r) begin
          err_nxt = ERR_SNAP_MISMATCH;
        end else begin
          snap_valid_nxt = 1'b0;
        end
      end
      default: err_nxt = ERR_OK;
    endcase
    if (!ctl.apply) we = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_word.command;
      idx_r   <= in_word.index;
      term_r  <= in_word.term;
      first_r <= in_word.first_of_batch;
    end
    if (ctl.eval) begin
      app_err_r   <= app_err_nxt;
      app_trunc_r <= app_trunc_nxt;
      keep_r      <= keep_nxt;
      hit_entry_r <= hit_entry_nxt;
      hit_snap_r  <= hit_snap_nxt;
      end_r       <= offset_r + XW'(count_r);
    end
    if (ctl.apply) begin
      found_r <= found_nxt;
      value_r <= value_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      count_r      <= '0;
      snap_valid_r <= 1'b0;
      snap_idx_r   <= '0;
      snap_term_r  <= '0;
    end else if (ctl.apply) begin
      offset_r     <= offset_nxt;
      count_r      <= count_nxt;
      snap_valid_r <= snap_valid_nxt;
      snap_idx_r   <= snap_idx_nxt;
      snap_term_r  <= snap_term_nxt;
    end
  end

  rult_ram #(
    .WIDTH (XW),
    .DEPTH (DEPTH)
  ) u_terms (
    .clk   (clk),
    .we    (we),
    .waddr (keep_r[AW-1:0]),
    .wdata (term_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // result word, built from the updated state
  always_comb begin
    out_word             = '0;
    out_word.term_found  = found_r;
    out_word.term_value  = value_r;
    out_word.error_code  = err_r;
    out_word.first_valid = snap_valid_r;
    if (snap_valid_r) out_word.first_index = snap_idx_r + XW'(1);
    if (count_r != '0) begin
      out_word.last_valid = 1'b1;
      out_word.last_index = offset_r + XW'(count_r) - XW'(1);
    end else if (snap_valid_r) begin
      out_word.last_valid = 1'b1;
      out_word.last_index = snap_idx_r;
    end
    if (!ctl.reply) out_word = '0;
  end

endmodule

@@ design/raft_unstable_log_term_store_unit.sv @@
// raft_unstable_log_term_store_unit: top level of the unstable log term store
//
//   channel  | handshake             | word
//   ---------+-----------------------+------------------------------
//   input    | start high, busy low  | in_word  (in_word_t)
//   result   | out_strobe, 1 cycle   | out_word (out_word_t)
//
// each command steps through evaluate, apply (term memory read data
// and state update), reply, and idle, in which the next word is taken.
// the term memory read and its registered output set the apply step.
// synchronous active-low reset clears offset, count and snapshot; the term
// memory is not cleared. results cannot be held off: out_strobe lasts one cycle.
`timescale 1ns / 1ps

module raft_unstable_log_term_store_unit import rult_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  ctl_t ctl;

  rult_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  rult_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_word  (in_word),
    .out_word (out_word)
  );

  assign out_strobe = ctl.reply;

endmodule
